### rtl/quaternion_to_rotation_matrix_unit_assert.svh
// Assertion macros used by the RTL back end (qrm_back).
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define QRM_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define QRM_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define QRM_ASSERT_IMP(label, clk, rst, a, b)
`define QRM_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

### rtl/qrm_pkg.sv
package qrm_pkg;
  localparam int COMP_W = 16;
  localparam int NLANE = 9;
  localparam int PROD_W = 32;
  localparam int MAG_W = 33;
  localparam int NUM_W = 35;
  localparam int QUO_W = 16;
  localparam int RES_W = 16;
  localparam int THR_W = 15;
  localparam int DIV_STEPS = QUO_W;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  localparam logic [THR_W-1:0] ONE_Q14 = 15'd16384;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1;

  // item handed from front to back: nine ratio magnitudes over one quadrance
  typedef struct packed {
    logic                          zero;
    logic [MAG_W-1:0]              quad;
    logic [NLANE-1:0]              neg;
    logic [NLANE-1:0][MAG_W-1:0]   mag;
  } qrm_work_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } qrm_lane_t;

  typedef struct packed {
    logic                   zero;
    logic [MAG_W-1:0]       quad;
    qrm_lane_t [NLANE-1:0]  lane;
  } qrm_div_t;

  // one restoring division step; first step does not shift
  function automatic qrm_lane_t qrm_step(qrm_lane_t a, logic [MAG_W-1:0] d, logic first);
    logic [MAG_W:0] r2;
    logic           ge;
    qrm_lane_t      o;
    r2 = first ? {1'b0, a.rem} : {a.rem, 1'b0};
    ge = (r2 >= {1'b0, d});
    o.neg = a.neg;
    o.quo = {a.quo[QUO_W-2:0], ge};
    o.rem = ge ? MAG_W'(r2 - {1'b0, d}) : r2[MAG_W-1:0];
    return o;
  endfunction
endpackage

### rtl/qrm_front.sv
module qrm_front import qrm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4*COMP_W-1:0] in_data,
  input  logic                full,
  output logic                push,
  output qrm_work_t           work
);
  logic en;
  logic va, vb, vc;
  // stage A: products
  logic signed [PROD_W-1:0] ww, xx, yy, zz, xy, xz, xt, yz, yt, zt;
  // stage B: numerators and quadrance
  logic signed [NUM_W-1:0]  num [NLANE];
  logic signed [NUM_W-1:0]  num_next [NLANE];
  logic [MAG_W-1:0]         quad, quad_next;
  logic signed [NUM_W-1:0]  e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_xt, e_yz, e_yt, e_zt;
  logic signed [COMP_W-1:0] cw, cx, cy, cz;
  qrm_work_t                work_next;

  assign en = !full;
  assign in_ready = en;
  assign push = en && vc;

  assign cw = in_data[COMP_W-1:0];
  assign cx = in_data[2*COMP_W-1:COMP_W];
  assign cy = in_data[3*COMP_W-1:2*COMP_W];
  assign cz = in_data[4*COMP_W-1:3*COMP_W];

  assign e_ww = NUM_W'(ww);
  assign e_xx = NUM_W'(xx);
  assign e_yy = NUM_W'(yy);
  assign e_zz = NUM_W'(zz);
  assign e_xy = NUM_W'(xy);
  assign e_xz = NUM_W'(xz);
  assign e_xt = NUM_W'(xt);
  assign e_yz = NUM_W'(yz);
  assign e_yt = NUM_W'(yt);
  assign e_zt = NUM_W'(zt);

  always_comb begin
    quad_next = MAG_W'($unsigned(ww)) + MAG_W'($unsigned(xx))
              + MAG_W'($unsigned(yy)) + MAG_W'($unsigned(zz));
    num_next[0] = e_ww + e_xx - e_yy - e_zz;
    num_next[1] = (e_xy + e_zt) <<< 1;
    num_next[2] = (e_xz - e_yt) <<< 1;
    num_next[3] = (e_xy - e_zt) <<< 1;
    num_next[4] = e_ww - e_xx + e_yy - e_zz;
    num_next[5] = (e_yz + e_xt) <<< 1;
    num_next[6] = (e_xz + e_yt) <<< 1;
    num_next[7] = (e_yz - e_xt) <<< 1;
    num_next[8] = e_ww - e_xx - e_yy + e_zz;
  end

  always_comb begin
    work_next.zero = (quad == '0);
    work_next.quad = quad;
    for (int i = 0; i < NLANE; i++) begin
      work_next.neg[i] = num[i][NUM_W-1];
      work_next.mag[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= cw * cw;
      xx <= cx * cx;
      yy <= cy * cy;
      zz <= cz * cz;
      xy <= cx * cy;
      xz <= cx * cz;
      xt <= cx * cw;
      yz <= cy * cz;
      yt <= cy * cw;
      zt <= cz * cw;
      quad <= quad_next;
      for (int i = 0; i < NLANE; i++) begin
        num[i] <= num_next[i];
      end
      work <= work_next;
    end
  end
endmodule

### rtl/qrm_fifo.sv
module qrm_fifo import qrm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  qrm_work_t wdata,
  output logic      full,
  input  logic      pop,
  output qrm_work_t rdata,
  output logic      empty
);
  qrm_work_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_CW-1:0] count;

  assign full = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

### rtl/qrm_back.sv
`include "quaternion_to_rotation_matrix_unit_assert.svh"
module qrm_back import qrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  qrm_work_t              head,
  input  logic                   empty,
  output logic                   pop,
  input  logic [THR_W-1:0]       thr,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NLANE*RES_W-1:0] out_data,
  output logic                   out_zero
);
  logic                   en;
  logic [DIV_STEPS-1:0]   sv;
  qrm_div_t               st [DIV_STEPS];
  qrm_div_t               st_next [DIV_STEPS];
  logic [NLANE*RES_W-1:0] data_next;
  logic                   range_ok;

  assign en = !out_valid || out_ready;
  assign pop = en && !empty;

  // one quotient bit per stage, nine lanes side by side
  always_comb begin
    qrm_lane_t l0;
    st_next[0].zero = head.zero;
    st_next[0].quad = head.quad;
    for (int i = 0; i < NLANE; i++) begin
      l0.rem = head.mag[i];
      l0.quo = '0;
      l0.neg = head.neg[i];
      st_next[0].lane[i] = qrm_step(l0, head.quad, 1'b1);
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      st_next[k].zero = st[k-1].zero;
      st_next[k].quad = st[k-1].quad;
      for (int i = 0; i < NLANE; i++) begin
        st_next[k].lane[i] = qrm_step(st[k-1].lane[i], st[k-1].quad, 1'b0);
      end
    end
  end

  // round half away, clamp, clean; identity on zero quadrance
  always_comb begin
    logic [QUO_W:0]          rs;
    logic [QUO_W-1:0]        q;
    logic [THR_W-1:0]        qs;
    logic signed [RES_W-1:0] v;
    for (int i = 0; i < NLANE; i++) begin
      rs = {1'b0, st[DIV_STEPS-1].lane[i].quo} + 1'b1;
      q = rs[QUO_W:1];
      qs = (q > QUO_W'(ONE_Q14)) ? ONE_Q14 : q[THR_W-1:0];
      v = st[DIV_STEPS-1].lane[i].neg ? -RES_W'(qs) : RES_W'(qs);
      if (qs < thr) begin
        v = '0;
      end
      if (st[DIV_STEPS-1].zero) begin
        v = (i % 4 == 0) ? RES_W'(ONE_Q14) : '0;
      end
      data_next[i*RES_W +: RES_W] = v;
    end
  end

  always_comb begin
    range_ok = 1'b1;
    for (int i = 0; i < NLANE; i++) begin
      if ($signed(out_data[i*RES_W +: RES_W]) > $signed(RES_W'(ONE_Q14)) ||
          $signed(out_data[i*RES_W +: RES_W]) < -$signed(RES_W'(ONE_Q14))) begin
        range_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv <= {sv[DIV_STEPS-2:0], !empty};
      out_valid <= sv[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        st[k] <= st_next[k];
      end
      out_data <= data_next;
      out_zero <= st[DIV_STEPS-1].zero;
    end
  end

  `QRM_ASSERT_IMP(a_range, clk, rst, out_valid, range_ok)
  `QRM_ASSERT_IMP(a_ident, clk, rst, out_valid && out_zero, out_data[RES_W-1:0] == RES_W'(ONE_Q14) && out_data[2*RES_W-1:RES_W] == '0)
  `QRM_ASSERT_NXT(a_drain, clk, rst, sv[DIV_STEPS-1] && en, out_valid)
endmodule

### rtl/quaternion_to_rotation_matrix_unit.sv
// Channel   Dir  Bits  Contents (low bits first)
// s_axis    in   64    comp_w, comp_x, comp_y, comp_z (signed Q3.12)
// m_axis    out  144   m00 m01 m02 m10 m11 m12 m20 m21 m22 (Q1.14); tuser zero_input
// cfg       in   15    clean_threshold
//
// One item per cycle sustained while m_axis_tready stays high; stages: 3 front,
// the queue, 16 divider stages, 1 output register.
// Divider: one restoring quotient bit per stage, nine lanes sharing the quadrance.
// rst (sync, high) clears all valids and sets clean_threshold to 1.
// A stalled output holds the back pipeline; the 2-item queue lets the front
// keep accepting until it fills, then s_axis_tready drops.
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [4*COMP_W-1:0]    s_axis_tdata,   // comp_w, comp_x, comp_y, comp_z
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [NLANE*RES_W-1:0] m_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output logic                   m_axis_tuser,   // zero_input
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THR_W-1:0]       cfg_data        // clean_threshold
);
  logic [THR_W-1:0] thr;
  logic             push, full, pop, empty;
  qrm_work_t        work, head;

  // threshold register; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // products, numerators, magnitudes and zero check
  qrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .full     (full),
    .push     (push),
    .work     (work)
  );

  qrm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (work),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .empty (empty)
  );

  // pipelined division, rounding, cleaning, output register
  qrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .thr       (thr),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_zero  (m_axis_tuser)
  );
endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrm_pkg::*;

  localparam int LATENCY = 30;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int CFG_INDEX_THRESHOLD = 0;
  localparam int N_RANDOM = 1500;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct {
    logic [15:0] m [9];
    logic        zero_input;
  } matrix_t;

  typedef struct {
    quat_t      q;
    logic       has_expect;
    logic [15:0] m [9];
    logic       zero_input;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  always #4 clk = ~clk;

  quaternion_to_rotation_matrix_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // threshold as the predictor sees it
  logic [14:0] thr_model = 15'd1;
  matrix_t expected_matrices [$];
  int mismatches = 0;
  int matrices_seen = 0;
  int identity_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  // round(num*2^14/den) ties away from zero, clamp, then clean below threshold
  function automatic logic [15:0] scaled_ratio(longint num, longint den);
    longint mag, q, v;
    mag = (num < 0) ? -num : num;
    q = (mag * 32768 + den) / (2 * den);
    if (q > 16384) q = 16384;
    v = (num < 0) ? -q : q;
    if (q < longint'(thr_model)) v = 0;
    return v[15:0];
  endfunction

  function automatic matrix_t rotation_of(quat_t q);
    matrix_t r;
    longint t, x, y, z, xx, xy, xz, xt, yy, yz, yt, zz, zt, n;
    t = q.w; x = q.x; y = q.y; z = q.z;
    xx = x*x; xy = x*y; xz = x*z; xt = x*t;
    yy = y*y; yz = y*z; yt = y*t; zz = z*z; zt = z*t;
    n = t*t + xx + yy + zz;
    if (n == 0) begin
      foreach (r.m[i]) r.m[i] = (i % 4 == 0) ? 16'd16384 : 16'd0;
      r.zero_input = 1'b1;
    end else begin
      r.m[0] = scaled_ratio(n - 2*(yy+zz), n);
      r.m[1] = scaled_ratio(2*(xy+zt), n);
      r.m[2] = scaled_ratio(2*(xz-yt), n);
      r.m[3] = scaled_ratio(2*(xy-zt), n);
      r.m[4] = scaled_ratio(n - 2*(xx+zz), n);
      r.m[5] = scaled_ratio(2*(yz+xt), n);
      r.m[6] = scaled_ratio(2*(xz+yt), n);
      r.m[7] = scaled_ratio(2*(yz-xt), n);
      r.m[8] = scaled_ratio(n - 2*(xx+yy), n);
      r.zero_input = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // drive one item, hold until accepted; sender idles beforehand at random
  task automatic send_quat(quat_t q, logic has_expect, matrix_t typed);
    matrix_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q.z, q.y, q.x, q.w};
    pred = rotation_of(q);
    if (has_expect) begin
      foreach (pred.m[i])
        if (pred.m[i] !== typed.m[i])
          report_mismatch("typed expectation vs predictor", pred.m[i], typed.m[i]);
      pred = typed;
    end
    expected_matrices.push_back(pred);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic quat_t rand_quat();
    quat_t q;
    int kind;
    kind = $urandom_range(9);
    q = {$urandom, $urandom};
    if (kind == 0) q = '0;                       // zero quaternion
    else if (kind < 4) begin                     // small magnitudes
      q.w = $signed(16'($urandom_range(8))) - 4;
      q.x = $signed(16'($urandom_range(8))) - 4;
      q.y = $signed(16'($urandom_range(8))) - 4;
      q.z = $signed(16'($urandom_range(8))) - 4;
    end else if (kind == 4) begin                // pure axis
      q = '0;
      case ($urandom_range(3))
        0: q.w = 16'($urandom);
        1: q.x = 16'($urandom);
        2: q.y = 16'($urandom);
        default: q.z = 16'($urandom);
      endcase
    end
    return q;
  endfunction

  // stop offering and wait for every expected matrix
  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // waits for the pipeline to drain before a register write
  task automatic drain();
    wait_empty();
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = v;
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    matrix_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      matrices_seen++;
      if (expected_matrices.size() == 0)
        report_mismatch("unexpected matrix, queue size", 1, 0);
      else begin
        want = expected_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (m_axis_tdata[16*i +: 16] !== want.m[i])
            report_mismatch($sformatf("m%0d%0d", i/3, i%3),
                            $signed(m_axis_tdata[16*i +: 16]), $signed(want.m[i]));
        if (m_axis_tuser !== want.zero_input)
          report_mismatch("zero_input", m_axis_tuser, want.zero_input);
        if (want.zero_input) identity_seen++;
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  directed_row_t directed [$];

  function automatic directed_row_t row(int w, int x, int y, int z, logic chk,
                                        int d0 = 0, int d1 = 0, int d2 = 0);
    directed_row_t r;
    r.q = {16'(w), 16'(x), 16'(y), 16'(z)};
    r.has_expect = chk;
    foreach (r.m[i]) r.m[i] = 16'd0;
    r.m[0] = 16'(d0); r.m[4] = 16'(d1); r.m[8] = 16'(d2);
    r.zero_input = 1'b0;
    return r;
  endfunction

  initial begin
    matrix_t typed;
    directed_row_t r;
    // rows with a diagonal result have typed diagonals; others use the predictor
    directed.push_back(row(0, 0, 0, 0, 1, 16384, 16384, 16384));      // zero quaternion
    directed.push_back(row(4096, 0, 0, 0, 1, 16384, 16384, 16384));   // unit scalar
    directed.push_back(row(-32768, 0, 0, 0, 1, 16384, 16384, 16384)); // most negative
    directed.push_back(row(32767, 0, 0, 0, 1, 16384, 16384, 16384));
    directed.push_back(row(0, 32767, 0, 0, 1, 16384, -16384, -16384)); // 180 about x
    directed.push_back(row(0, 0, -32768, 0, 1, -16384, 16384, -16384));
    directed.push_back(row(0, 0, 0, 1, 1, -16384, -16384, 16384));
    directed.push_back(row(32767, 32767, 32767, 32767, 0));
    directed.push_back(row(-32768, -32768, -32768, -32768, 0));
    directed.push_back(row(-32768, 32767, -32768, 32767, 0));
    directed.push_back(row(1, 1, 1, 1, 0));
    directed.push_back(row(1, 1, 0, 0, 0));                            // 90 about x
    directed.push_back(row(3, 1, 0, 0, 0));
    directed.push_back(row(2896, 2896, 0, 0, 0));
    directed.push_back(row(-1, 2, -3, 4, 0));
    directed.push_back(row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset threshold
    foreach (directed[k]) begin
      r = directed[k];
      typed.m = r.m;
      typed.zero_input = (r.q == '0);
      send_quat(r.q, r.has_expect, typed);
    end

    // phases: threshold settings crossed with idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_threshold(15'd0);
        1: write_threshold(15'd16384);
        2: write_threshold(15'h7fff);
        3: write_threshold(15'($urandom_range(200)));
        4: write_threshold(15'($urandom_range(16385)));
        default: write_threshold(15'd1);
      endcase
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 84 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 84 : (ph % 4 == 3) ? 26 : 0;
      if (ph == 3) send_idle_pct = 26;
      if (ph == 0) hold_off = 200;  // long receiver hold-off while sending
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        typed.zero_input = 1'b0;
        send_quat(rand_quat(), 1'b0, typed);
        // once per phase the sender waits for everything to come back
        if (k == 50) wait_empty();
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_empty();
    repeat (LATENCY) @(posedge clk);

    $display("Covered %0d matrices (%0d zero-quaternion identities) over six threshold",
             matrices_seen, identity_seen);
    $display("settings incl. 0, 16384 and 32767, with input and output idling phases.");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/qrm_pkg.sv
rtl/qrm_front.sv
rtl/qrm_fifo.sv
rtl/qrm_back.sv
rtl/quaternion_to_rotation_matrix_unit.sv
tb/tb.sv
